[rtl/weighted_adjacency_table_macros.svh]
// Assertion macros for the adjacency table checker
`ifndef WEIGHTED_ADJACENCY_TABLE_MACROS_SVH
`define WEIGHTED_ADJACENCY_TABLE_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define WAT_AST_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define WAT_AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/wat_pkg.sv]
// Shared constants and types for the weighted adjacency table
package wat_pkg;

	// default sizing
	localparam int NUM_VERTICES_DEF = 64;
	localparam int MAX_DEGREE_DEF   = 16;
	localparam int WEIGHT_BITS_DEF  = 32;

	// fixed port widths
	localparam int CMD_W     = 2;
	localparam int VTX_W     = 6;
	localparam int WGT_W     = 32;
	localparam int DEG_OUT_W = 5;
	localparam int TOT_OUT_W = 11;

	// command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_ADD    = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_LIST   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DEG,
		ST_SCAN
	} state_t;

endpackage

[rtl/wat_ram.sv]
// Generic simple dual-port RAM, one write port, one registered read port
module wat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/weighted_adjacency_table.sv]
// Weighted directed graph as fixed-capacity per-vertex adjacency lists
//
//  channel   handshake                beat contents
//  --------  -----------------------  ---------------------------------------------
//  command   start, busy (out)        cmd, src_vertex, dst_vertex, edge_weight
//  config    cfg_valid, cfg_ready     absent_weight
//  result    result_valid (strobe)    found, weight_out, neighbor_vertex,
//                                     out_degree, total_edges, status, last
//
// Add: degree RAM read in ST_DEG, result registered from there; a new command may start as it shows.
// Look up / list: one degree-RAM read, then one edge-RAM entry per cycle through a
// single compare path; list results stream on consecutive cycles.
// After reset, a clearing pass zeroes the degree RAM with busy high; config writes
// are always taken. The result side has no stall.
module weighted_adjacency_table #(
	parameter int NUM_VERTICES = wat_pkg::NUM_VERTICES_DEF,
	parameter int MAX_DEGREE   = wat_pkg::MAX_DEGREE_DEF,
	parameter int WEIGHT_BITS  = wat_pkg::WEIGHT_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// command
	input  logic                                 start,
	output logic                                 busy,
	input  logic [wat_pkg::CMD_W-1:0]            cmd,
	input  logic [wat_pkg::VTX_W-1:0]            src_vertex,
	input  logic [wat_pkg::VTX_W-1:0]            dst_vertex,
	input  logic signed [wat_pkg::WGT_W-1:0]     edge_weight,
	// config
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic signed [wat_pkg::WGT_W-1:0]     absent_weight,
	// result
	output logic                                 result_valid,
	output logic                                 found,
	output logic signed [wat_pkg::WGT_W-1:0]     weight_out,
	output logic [wat_pkg::VTX_W-1:0]            neighbor_vertex,
	output logic [wat_pkg::DEG_OUT_W-1:0]        out_degree,
	output logic [wat_pkg::TOT_OUT_W-1:0]        total_edges,
	output logic                                 status,
	output logic                                 last
);

	localparam int VW    = $clog2(NUM_VERTICES);
	localparam int SLOTS = NUM_VERTICES * MAX_DEGREE;
	localparam int AW    = $clog2(SLOTS);
	localparam int DW    = $clog2(MAX_DEGREE + 1);
	localparam int TW    = $clog2(SLOTS + 1);
	localparam int EW    = wat_pkg::VTX_W + WEIGHT_BITS;

	// vertex number modulo NUM_VERTICES by conditional subtraction
	function automatic logic [wat_pkg::VTX_W-1:0] vtx_mod(input logic [wat_pkg::VTX_W-1:0] v);
		logic [wat_pkg::VTX_W-1:0] r;
		r = v;
		for (int k = wat_pkg::VTX_W - 1; k >= 0; k--) begin
			if (32'(r) >= (NUM_VERTICES << k)) begin
				r = r - wat_pkg::VTX_W'(NUM_VERTICES << k);
			end
		end
		return r;
	endfunction

	wat_pkg::state_t state_q, state_d;

	// captured command
	wat_pkg::cmd_t                   cmd_q;
	logic [VW-1:0]                   src_q;
	logic [wat_pkg::VTX_W-1:0]       dst_q;
	logic signed [wat_pkg::WGT_W-1:0] wgt_q;
	logic [AW-1:0]                   base_q;

	// control counters
	logic [DW-1:0] deg_q, deg_d;
	logic [DW-1:0] rd_idx_q, rd_idx_d;
	logic [DW-1:0] chk_idx_q, chk_idx_d;
	logic [VW-1:0] clr_q, clr_d;
	logic [TW-1:0] tot_q, tot_d;
	logic signed [wat_pkg::WGT_W-1:0] absent_q;

	// memories
	logic [VW-1:0] src_idx;
	logic          deg_we;
	logic [VW-1:0] deg_waddr;
	logic [DW-1:0] deg_wdata;
	logic [DW-1:0] deg_rd;
	logic          edge_we;
	logic [EW-1:0] edge_rdata;
	logic [wat_pkg::VTX_W-1:0]       ent_dst;
	logic signed [WEIGHT_BITS-1:0]   ent_w;
	logic                            accept;
	logic                            is_last;

	// next result
	logic                                res_v_d, res_f_d, res_s_d, res_l_d;
	logic signed [wat_pkg::WGT_W-1:0]    res_w_d;
	logic [wat_pkg::VTX_W-1:0]           res_n_d;
	logic [DW-1:0]                       res_deg_d;

	assign accept    = start && (state_q == wat_pkg::ST_IDLE);
	assign busy      = (state_q != wat_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign src_idx   = VW'(vtx_mod(src_vertex));
	assign ent_dst   = edge_rdata[EW-1:WEIGHT_BITS];
	assign ent_w     = edge_rdata[WEIGHT_BITS-1:0];
	assign is_last   = (chk_idx_q == DW'(deg_q - 1'b1));

	wat_ram #(.WIDTH(DW), .DEPTH(NUM_VERTICES)) u_deg_ram (
		.clk   (clk),
		.we    (deg_we),
		.waddr (deg_waddr),
		.wdata (deg_wdata),
		.raddr (src_idx),
		.rdata (deg_rd)
	);

	wat_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_edge_ram (
		.clk   (clk),
		.we    (edge_we),
		.waddr (base_q + AW'(deg_rd)),
		.wdata ({dst_q, WEIGHT_BITS'(wgt_q)}),
		.raddr (base_q + AW'(rd_idx_q)),
		.rdata (edge_rdata)
	);

	// sequencer: next state, memory writes, result
	always_comb begin
		state_d   = state_q;
		deg_d     = deg_q;
		rd_idx_d  = rd_idx_q;
		chk_idx_d = chk_idx_q;
		clr_d     = clr_q;
		tot_d     = tot_q;
		deg_we    = 1'b0;
		deg_waddr = src_q;
		deg_wdata = DW'(deg_rd + 1'b1);
		edge_we   = 1'b0;
		res_v_d   = 1'b0;
		res_f_d   = 1'b0;
		res_w_d   = absent_q;
		res_n_d   = dst_q;
		res_deg_d = deg_q;
		res_s_d   = 1'b0;
		res_l_d   = 1'b1;
		unique case (state_q)
			wat_pkg::ST_CLEAR: begin
				deg_we    = 1'b1;
				deg_waddr = clr_q;
				deg_wdata = '0;
				clr_d     = VW'(clr_q + 1'b1);
				if (clr_q == VW'(NUM_VERTICES - 1)) begin
					state_d = wat_pkg::ST_IDLE;
				end
			end
			wat_pkg::ST_IDLE: begin
				if (start) begin
					state_d   = wat_pkg::ST_DEG;
					rd_idx_d  = '0;
					chk_idx_d = '0;
				end
			end
			wat_pkg::ST_DEG: begin
				deg_d     = deg_rd;
				res_deg_d = deg_rd;
				state_d   = wat_pkg::ST_IDLE;
				unique case (cmd_q) inside
					wat_pkg::CMD_ADD: begin
						res_v_d = 1'b1;
						res_w_d = wgt_q;
						if (deg_rd >= DW'(MAX_DEGREE)) begin
							res_s_d = 1'b1;
						end else begin
							edge_we   = 1'b1;
							deg_we    = 1'b1;
							tot_d     = TW'(tot_q + 1'b1);
							res_f_d   = 1'b1;
							res_deg_d = DW'(deg_rd + 1'b1);
						end
					end
					wat_pkg::CMD_LOOKUP, wat_pkg::CMD_LIST: begin
						if (deg_rd == '0) begin
							res_v_d = 1'b1;
							if (cmd_q == wat_pkg::CMD_LIST) begin
								res_n_d = '0;
							end
						end else begin
							state_d  = wat_pkg::ST_SCAN;
							rd_idx_d = DW'(1);
						end
					end
					default: begin
					end
				endcase
			end
			wat_pkg::ST_SCAN: begin
				// edge_rdata holds entry chk_idx_q; entry rd_idx_q is being read
				if (cmd_q == wat_pkg::CMD_LOOKUP) begin
					if (ent_dst == dst_q) begin
						res_v_d = 1'b1;
						res_f_d = 1'b1;
						res_w_d = wat_pkg::WGT_W'(ent_w);
						state_d = wat_pkg::ST_IDLE;
					end else if (is_last) begin
						res_v_d = 1'b1;
						state_d = wat_pkg::ST_IDLE;
					end
				end else begin
					res_v_d = 1'b1;
					res_f_d = 1'b1;
					res_w_d = wat_pkg::WGT_W'(ent_w);
					res_n_d = ent_dst;
					res_l_d = is_last;
					if (is_last) begin
						state_d = wat_pkg::ST_IDLE;
					end
				end
				if (state_d == wat_pkg::ST_SCAN) begin
					chk_idx_d = DW'(chk_idx_q + 1'b1);
					rd_idx_d  = DW'(rd_idx_q + 1'b1);
				end
			end
			default: begin
				state_d = wat_pkg::ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wat_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q        <= '0;
			rd_idx_q     <= '0;
			chk_idx_q    <= '0;
			clr_q        <= '0;
			tot_q        <= '0;
			absent_q     <= 32'sh7FFF_FFFF;
			result_valid <= 1'b0;
		end else begin
			deg_q        <= deg_d;
			rd_idx_q     <= rd_idx_d;
			chk_idx_q    <= chk_idx_d;
			clr_q        <= clr_d;
			tot_q        <= tot_d;
			result_valid <= res_v_d;
			if (cfg_valid) begin
				absent_q <= absent_weight;
			end
		end
	end

	// command capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= wat_pkg::cmd_t'(cmd);
			src_q  <= src_idx;
			dst_q  <= vtx_mod(dst_vertex);
			wgt_q  <= edge_weight;
			base_q <= AW'(src_idx) * AW'(MAX_DEGREE);
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (res_v_d) begin
			found           <= res_f_d;
			weight_out      <= res_w_d;
			neighbor_vertex <= res_n_d;
			out_degree      <= wat_pkg::DEG_OUT_W'(res_deg_d);
			total_edges     <= wat_pkg::TOT_OUT_W'(tot_d);
			status          <= res_s_d;
			last            <= res_l_d;
		end
	end

endmodule

[rtl/wat_chk.sv]
// Port-level checker for the adjacency table, bound to the top level
`include "weighted_adjacency_table_macros.svh"

module wat_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic result_valid,
	input logic found,
	input logic status,
	input logic last
);

	// an accepted command makes the block busy in the next cycle
	`WAT_AST_NEXT(a_accept_busy, start && !busy, busy, "not busy after accept")

	// a non-final result is followed directly by the next one
	`WAT_AST_NEXT(a_stream_cont, result_valid && !last, result_valid, "result stream broke")

	// more results pending means the block is still busy
	`WAT_AST_NOW(a_stream_busy, result_valid && !last, busy, "idle with results pending")

	// a rejected add is a single final result with found clear
	`WAT_AST_NOW(a_reject_shape, result_valid && status, !found && last, "bad reject result")

endmodule

bind weighted_adjacency_table wat_chk u_wat_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.found        (found),
	.status       (status),
	.last         (last)
);
